### rtl/core/qvr_pkg.sv
// Shared widths, payload types and constants for the quaternion vector rotator.
`default_nettype none

package qvr_pkg;

    localparam int COMP_W     = 16;
    localparam int FRAC_W     = COMP_W - 2;
    localparam int PROD_W     = 2 * COMP_W;
    localparam int PSUM_W     = PROD_W + 1;
    localparam int PPROD_W    = PSUM_W + COMP_W;
    localparam int RSUM_W     = PPROD_W + 1;
    localparam int RND_SHIFT  = 2 * FRAC_W;
    localparam int TRIM_W     = RSUM_W - RND_SHIFT;
    localparam int NUM_PROD   = 12;
    localparam int NUM_AXES   = 3;

    typedef logic signed [COMP_W-1:0]  comp_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [PSUM_W-1:0]  psum_t;
    typedef logic signed [PPROD_W-1:0] pprod_t;
    typedef logic signed [RSUM_W-1:0]  rsum_t;
    typedef logic signed [TRIM_W-1:0]  trim_t;

    localparam comp_t SAT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t SAT_MIN = {1'b1, {(COMP_W-1){1'b0}}};
    localparam rsum_t ROUND_BIAS = rsum_t'(1) <<< (RND_SHIFT - 1);

    typedef struct packed {
        comp_t quat_x;
        comp_t quat_y;
        comp_t quat_z;
        comp_t quat_w;
        comp_t vec_x;
        comp_t vec_y;
        comp_t vec_z;
    } in_t;

    typedef struct packed {
        comp_t rot_x;
        comp_t rot_y;
        comp_t rot_z;
        logic  clipped;
    } out_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
        comp_t w;
    } quat_t;

    // Intermediate quaternion p = q * (v, 0), carried with q itself.
    typedef struct packed {
        quat_t quat;
        psum_t p_x;
        psum_t p_y;
        psum_t p_z;
        psum_t p_w;
    } pq_t;

    // Vector part of p * conj(q), already biased for rounding.
    typedef struct packed {
        rsum_t r_x;
        rsum_t r_y;
        rsum_t r_z;
    } rvec_t;

endpackage

`default_nettype wire

### rtl/core/qvr_vmul.sv
// First product q * (v, 0): a multiply stage followed by a sum stage.
`default_nettype none

module qvr_vmul
    import qvr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output pq_t       out_data
);

    logic  v1_reg, v1_next, v2_reg, v2_next;
    logic  ready1, ready2;
    prod_t prod_reg [NUM_PROD];
    prod_t prod_next [NUM_PROD];
    quat_t quat_reg, quat_next;
    pq_t   pq_reg, pq_next;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    assign v1_next = ready1 ? in_valid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;

    // Product order: three terms each of p_x, p_y, p_z, then the three dot terms of p_w.
    always_comb
    begin
        prod_next[0]  = prod_t'(in_data.quat_w) * prod_t'(in_data.vec_x);
        prod_next[1]  = prod_t'(in_data.quat_y) * prod_t'(in_data.vec_z);
        prod_next[2]  = prod_t'(in_data.quat_z) * prod_t'(in_data.vec_y);
        prod_next[3]  = prod_t'(in_data.quat_w) * prod_t'(in_data.vec_y);
        prod_next[4]  = prod_t'(in_data.quat_z) * prod_t'(in_data.vec_x);
        prod_next[5]  = prod_t'(in_data.quat_x) * prod_t'(in_data.vec_z);
        prod_next[6]  = prod_t'(in_data.quat_w) * prod_t'(in_data.vec_z);
        prod_next[7]  = prod_t'(in_data.quat_x) * prod_t'(in_data.vec_y);
        prod_next[8]  = prod_t'(in_data.quat_y) * prod_t'(in_data.vec_x);
        prod_next[9]  = prod_t'(in_data.quat_x) * prod_t'(in_data.vec_x);
        prod_next[10] = prod_t'(in_data.quat_y) * prod_t'(in_data.vec_y);
        prod_next[11] = prod_t'(in_data.quat_z) * prod_t'(in_data.vec_z);
        quat_next.x   = in_data.quat_x;
        quat_next.y   = in_data.quat_y;
        quat_next.z   = in_data.quat_z;
        quat_next.w   = in_data.quat_w;
    end

    always_comb
    begin
        pq_next.quat = quat_reg;
        pq_next.p_x  = psum_t'(prod_reg[0]) + psum_t'(prod_reg[1]) - psum_t'(prod_reg[2]);
        pq_next.p_y  = psum_t'(prod_reg[3]) + psum_t'(prod_reg[4]) - psum_t'(prod_reg[5]);
        pq_next.p_z  = psum_t'(prod_reg[6]) + psum_t'(prod_reg[7]) - psum_t'(prod_reg[8]);
        pq_next.p_w  = -(psum_t'(prod_reg[9]) + psum_t'(prod_reg[10])
                         + psum_t'(prod_reg[11]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            prod_reg <= prod_next;
            quat_reg <= quat_next;
        end
        if (ready2 && v1_reg)
        begin
            pq_reg <= pq_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = pq_reg;

`ifndef SYNTH
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted transfer did not reach the multiply stage");
`endif

endmodule

`default_nettype wire

### rtl/core/qvr_pmul.sv
// Second product p * conj(q), vector part: a multiply stage followed by a sum stage.
`default_nettype none

module qvr_pmul
    import qvr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire pq_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output rvec_t     out_data
);

    logic   v1_reg, v1_next, v2_reg, v2_next;
    logic   ready1, ready2;
    pprod_t prod_reg [NUM_PROD];
    pprod_t prod_next [NUM_PROD];
    rvec_t  r_reg, r_next;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    assign v1_next = ready1 ? in_valid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;

    // Four terms per axis, in the order they are summed below.
    always_comb
    begin
        prod_next[0]  = pprod_t'(in_data.p_x) * pprod_t'(in_data.quat.w);
        prod_next[1]  = pprod_t'(in_data.p_w) * pprod_t'(in_data.quat.x);
        prod_next[2]  = pprod_t'(in_data.p_y) * pprod_t'(in_data.quat.z);
        prod_next[3]  = pprod_t'(in_data.p_z) * pprod_t'(in_data.quat.y);
        prod_next[4]  = pprod_t'(in_data.p_y) * pprod_t'(in_data.quat.w);
        prod_next[5]  = pprod_t'(in_data.p_w) * pprod_t'(in_data.quat.y);
        prod_next[6]  = pprod_t'(in_data.p_z) * pprod_t'(in_data.quat.x);
        prod_next[7]  = pprod_t'(in_data.p_x) * pprod_t'(in_data.quat.z);
        prod_next[8]  = pprod_t'(in_data.p_z) * pprod_t'(in_data.quat.w);
        prod_next[9]  = pprod_t'(in_data.p_w) * pprod_t'(in_data.quat.z);
        prod_next[10] = pprod_t'(in_data.p_x) * pprod_t'(in_data.quat.y);
        prod_next[11] = pprod_t'(in_data.p_y) * pprod_t'(in_data.quat.x);
    end

    // The rounding bias is folded into the final sum so the last stage only shifts and saturates, with no add.
    always_comb
    begin
        r_next.r_x = rsum_t'(prod_reg[0]) - rsum_t'(prod_reg[1])
                   - rsum_t'(prod_reg[2]) + rsum_t'(prod_reg[3]) + ROUND_BIAS;
        r_next.r_y = rsum_t'(prod_reg[4]) - rsum_t'(prod_reg[5])
                   - rsum_t'(prod_reg[6]) + rsum_t'(prod_reg[7]) + ROUND_BIAS;
        r_next.r_z = rsum_t'(prod_reg[8]) - rsum_t'(prod_reg[9])
                   - rsum_t'(prod_reg[10]) + rsum_t'(prod_reg[11]) + ROUND_BIAS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (ready2 && v1_reg)
        begin
            r_reg <= r_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = r_reg;

`ifndef SYNTH
    a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && ready2 |=> v2_reg)
        else $error("multiply stage result was dropped before the sum stage");
`endif

endmodule

`default_nettype wire

### rtl/core/qvr_sat.sv
// Output stage: drops the fraction bits, saturates each axis and registers the result.
`default_nettype none

module qvr_sat
    import qvr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire rvec_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output out_t       out_data
);

    logic  v_reg, v_next;
    out_t  out_reg, out_next;
    rsum_t acc [NUM_AXES];
    rsum_t shifted [NUM_AXES];
    trim_t trim [NUM_AXES];
    comp_t rot [NUM_AXES];
    logic  [NUM_AXES-1:0] clip;

    assign in_ready = !v_reg || out_ready;
    assign v_next   = in_ready ? in_valid : v_reg;

    assign acc[0] = in_data.r_x;
    assign acc[1] = in_data.r_y;
    assign acc[2] = in_data.r_z;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            shifted[i] = acc[i] >>> RND_SHIFT;
            trim[i]    = shifted[i][TRIM_W-1:0];
            if (trim[i] > trim_t'(SAT_MAX))
            begin
                rot[i]  = SAT_MAX;
                clip[i] = 1'b1;
            end
            else if (trim[i] < trim_t'(SAT_MIN))
            begin
                rot[i]  = SAT_MIN;
                clip[i] = 1'b1;
            end
            else
            begin
                rot[i]  = trim[i][COMP_W-1:0];
                clip[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_next.rot_x   = rot[0];
        out_next.rot_y   = rot[1];
        out_next.rot_z   = rot[2];
        out_next.clipped = |clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.clipped |->
            (out_data.rot_x == SAT_MAX || out_data.rot_x == SAT_MIN
             || out_data.rot_y == SAT_MAX || out_data.rot_y == SAT_MIN
             || out_data.rot_z == SAT_MAX || out_data.rot_z == SAT_MIN))
        else $error("clip flag set but no axis sits at a bound");
`endif

endmodule

`default_nettype wire

### rtl/core/quaternion_vector_rotate.sv
// Throughput: one item per cycle while out_ready is held high; every stage holds one item
// and advances when the next is free.
// Stages: q*v multiply, p sum, p*conj(q) multiply, r sum with bias, shift and saturate.
// Reset clears only the stage valid bits; no data is held between items.
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    logic  pq_valid, pq_ready;
    pq_t   pq_data;
    logic  r_valid, r_ready;
    rvec_t r_data;

    qvr_vmul u_vmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (pq_valid),
        .out_ready (pq_ready),
        .out_data  (pq_data)
    );

    qvr_pmul u_pmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pq_valid),
        .in_ready  (pq_ready),
        .in_data   (pq_data),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_data  (r_data)
    );

    qvr_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_data   (r_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTH
    a_empty_output_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled although the output stage is empty");

    a_draining_output_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready && pq_ready && r_ready)
        else $error("pipeline stalled while the output is being taken");
`endif

endmodule

`default_nettype wire
